/* rtl/pcmcv_pkg.sv */
// Package: shared widths, format codes and register indexes for the PCM converter.
`timescale 1ns / 1ps
package pcmcv_pkg;
    localparam int RAW_W  = 32;
    localparam int PCM_W  = 16;
    localparam int BITS_W = 6;
    localparam int CFG_W  = 6;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_SAMPLE_IS_FLOAT = 1'd0;
    localparam logic [IDX_W-1:0] REG_SAMPLE_BITS     = 1'd1;

    localparam logic [BITS_W-1:0] BITS_RESET = 6'd16;
    localparam logic [BITS_W-1:0] BITS_8     = 6'd8;
    localparam logic [BITS_W-1:0] BITS_16    = 6'd16;
    localparam logic [BITS_W-1:0] BITS_24    = 6'd24;
    localparam logic [BITS_W-1:0] BITS_32    = 6'd32;

    // 32767 as a 24-bit significand (with hidden bit) scaled by 2^-9
    localparam logic [23:0] SCALE_MANT = 24'hFFFE00;

    typedef struct packed {
        logic                 is_float;
        logic [BITS_W-1:0]    bits;
    } cfg_t;
endpackage

/* rtl/pcmcv_float.sv */
// Float to 16-bit PCM: Inf/NaN -> 0; clamp, scale by 32767, two roundings, last half away.
`timescale 1ns / 1ps
module pcmcv_float
(
    input  logic [31:0] raw,
    output logic [15:0] pcm
);
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] mant;
    logic [47:0] prod;
    logic [23:0] pm;
    logic [8:0]  pe;
    logic [23:0] fm;
    logic [24:0] fr;
    logic [23:0] sm;
    logic [8:0]  se;
    logic [31:0] fixed;
    logic [7:0]  sh;
    logic [16:0] mag;
    logic [7:0]  fracb;
    logic        half;

    always_comb
    begin
        sgn  = raw[31];
        ex   = raw[30:23];
        mant = {(ex != 8'd0), raw[22:0]};
        prod = '0; pm = '0; pe = '0; fm = '0; fr = '0; sm = '0; se = '0;
        fixed = '0; sh = '0; mag = '0; fracb = '0; half = 1'b0;
        if (ex == 8'hFF)
        begin
            pcm = '0;
        end
        else if ((ex > 8'd127) || ((ex == 8'd127) && (raw[22:0] != 23'd0)))
        begin
            pcm = sgn ? 16'h8001 : 16'h7FFF;
        end
        else
        begin
            // float product: value = mant*2^(ex-150) * SCALE_MANT*2^-9
            prod = mant * pcmcv_pkg::SCALE_MANT;
            if (prod[47])
            begin
                pm = prod[47:24];
                fr = {1'b0, pm} + {24'd0, prod[23] & ((|prod[22:0]) | pm[0])};
                pe = {1'b0, ex} + 9'd1;
            end
            else
            begin
                pm = prod[46:23];
                fr = {1'b0, pm} + {24'd0, prod[22] & ((|prod[21:0]) | pm[0])};
                pe = {1'b0, ex};
            end
            // subnormal inputs give products far below 0.5 -> zero
            if (fr[24])
            begin
                sm = fr[24:1];
                se = pe + 9'd1;
            end
            else
            begin
                sm = fr[23:0];
                se = pe;
            end
            fm = sm;
            // value = fm * 2^(se - 127 - 23 + 14); want integer and 8 fraction bits
            // fixed = value * 2^8 = fm >> (23-14-8 - (se-127)) = fm >> (128 - se)
            if (se >= 9'd112 && se <= 9'd128)
            begin
                sh = 8'(9'd128 - se);
                fixed = {8'd0, fm} >> sh;
            end
            else
            begin
                fixed = '0;
            end
            mag   = fixed[24:8];
            fracb = fixed[7:0];
            half  = fracb[7];
            if (ex == 8'd0 || fixed == '0)
                pcm = '0;
            else
            begin
                mag = mag + {16'd0, half};
                pcm = sgn ? 16'(-mag) : mag[15:0];
            end
        end
    end
endmodule

/* rtl/pcmcv_conv.sv */
// Format selection for one sample: float, integer widths, silent forcing.
`timescale 1ns / 1ps
module pcmcv_conv
(
    input  pcmcv_pkg::cfg_t   cfg,
    input  logic [31:0]       raw,
    input  logic              silent,
    output logic [15:0]       pcm
);
    logic [15:0] fpcm;

    pcmcv_float u_float
    (
        .raw (raw),
        .pcm (fpcm)
    );

    always_comb
    begin
        if (silent)
            pcm = '0;
        else if (cfg.is_float && (cfg.bits >= pcmcv_pkg::BITS_32))
            pcm = fpcm;
        else
        begin
            case (cfg.bits)
                pcmcv_pkg::BITS_16: pcm = raw[15:0];
                pcmcv_pkg::BITS_24: pcm = raw[23:8];
                pcmcv_pkg::BITS_32: pcm = raw[31:16];
                pcmcv_pkg::BITS_8:  pcm = {~raw[7], raw[6:0], 8'd0};
                default:            pcm = '0;
            endcase
        end
    end
endmodule

/* rtl/pcm_sample_to_int16_core.sv */
// Top level: PCM sample converter with config registers, input and result registers.
`timescale 1ns / 1ps
// Usage:
//   Pulse start with sample_raw, silent and last_in_packet to present one beat.
//   A beat is taken whenever start is high and busy is low; busy is always low,
//   so one sample can enter every cycle.
//   The beat is captured into an input register, converted by one pass of
//   combinational logic, and lands in the result register: done strobes for one
//   cycle with pcm_sample and last_out when the result register is loaded.
//   Throughput is one sample per cycle, set by the single conversion stage.
//   Configuration: cfg_we with cfg_index (0 = sample_is_float, 1 = sample_bits)
//   and cfg_data writes a register at the edge; write only while idle.
//   Reset clears the valid flags and restores sample_is_float = 0,
//   sample_bits = 16. The receiver cannot stall: each result is shown once,
//   for exactly one cycle.
module pcm_sample_to_int16_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pcmcv_pkg::RAW_W-1:0]       sample_raw,
    input  logic                              silent,
    input  logic                              last_in_packet,
    input  logic                              cfg_we,
    input  logic [pcmcv_pkg::IDX_W-1:0]       cfg_index,
    input  logic [pcmcv_pkg::CFG_W-1:0]       cfg_data,
    output logic                              done,
    output logic signed [pcmcv_pkg::PCM_W-1:0] pcm_sample,
    output logic                              last_out
);
    pcmcv_pkg::cfg_t              cfg_reg;
    logic                         in_vld_reg;
    logic [pcmcv_pkg::RAW_W-1:0]  raw_reg;
    logic                         silent_reg;
    logic                         last_reg;
    logic                         out_vld_reg;
    logic [pcmcv_pkg::PCM_W-1:0]  pcm_reg;
    logic                         lastq_reg;
    logic [pcmcv_pkg::PCM_W-1:0]  pcm_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_float <= 1'b0;
            cfg_reg.bits     <= pcmcv_pkg::BITS_RESET;
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == pcmcv_pkg::REG_SAMPLE_IS_FLOAT)
                cfg_reg.is_float <= cfg_data[0];
            if (cfg_we && cfg_index == pcmcv_pkg::REG_SAMPLE_BITS)
                cfg_reg.bits <= cfg_data;
            in_vld_reg  <= start && !busy;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            raw_reg    <= sample_raw;
            silent_reg <= silent;
            last_reg   <= last_in_packet;
        end
        if (in_vld_reg)
        begin
            pcm_reg   <= pcm_next;
            lastq_reg <= last_reg;
        end
    end

    pcmcv_conv u_conv
    (
        .cfg    (cfg_reg),
        .raw    (raw_reg),
        .silent (silent_reg),
        .pcm    (pcm_next)
    );

    assign done       = out_vld_reg;
    assign pcm_sample = pcm_reg;
    assign last_out   = lastq_reg;

`ifndef NO_ASSERTIONS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat gave no result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_vld_reg))
        else $error("result without beat");
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && silent_reg) |=> (pcm_sample == '0))
        else $error("silent beat gave nonzero sample");
`endif
endmodule
